// File: hw/rtl/rdt_pkg.sv
// rdt_pkg: shared types and codes for the reliable datagram tracker
// no dependencies; used by rdt_out_reg and reliable_datagram_tracker
package rdt_pkg;

  // input function codes
  localparam logic [2:0] FUNC_SEND = 3'd0;
  localparam logic [2:0] FUNC_ACK  = 3'd1;
  localparam logic [2:0] FUNC_DATA = 3'd2;
  localparam logic [2:0] FUNC_TICK = 3'd3;

  // result kinds
  localparam logic [3:0] KIND_PASSED      = 4'd0;
  localparam logic [3:0] KIND_STORED      = 4'd1;
  localparam logic [3:0] KIND_ACK_CLEARED = 4'd2;
  localparam logic [3:0] KIND_DELIVERED   = 4'd3;
  localparam logic [3:0] KIND_DUPLICATE   = 4'd4;
  localparam logic [3:0] KIND_BAD_ACK     = 4'd5;
  localparam logic [3:0] KIND_TOO_SHORT   = 4'd6;
  localparam logic [3:0] KIND_RESEND      = 4'd7;
  localparam logic [3:0] KIND_TICK_DONE   = 4'd8;

  // one result word
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  peer;
    logic [31:0] seq;
    logic [4:0]  slot;
    logic [16:0] len;
    logic        send_ack;
    logic        last;
  } rdt_result_t;

endpackage

// File: hw/rtl/rdt_slot_mod.sv
// rdt_slot_mod: iterative remainder of a 32-bit sequence number by the window size
// eight bits per cycle; no package dependencies
module rdt_slot_mod #(
  parameter int WINDOW = 32,
  localparam int SL_W = $clog2(WINDOW)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [31:0]     value,
  output logic            done,
  output logic [SL_W-1:0] rem
);

  localparam int STEP_BITS = 8;
  localparam int STEPS = 32 / STEP_BITS;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [SL_W:0] WIN = (SL_W + 1)'(WINDOW);

  logic [31:0]      sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SL_W-1:0]  rem_next;

  // restoring reduction, one bit per inner step
  always_comb begin : reduce
    logic [SL_W-1:0] acc;
    logic [SL_W:0]   t;
    acc = rem;
    t = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {acc, sh[31 - i]};
      if (t >= WIN) begin
        t = t - WIN;
      end
      acc = t[SL_W-1:0];
    end
    rem_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= value;
      rem <= '0;
    end else if (busy) begin
      sh  <= sh << STEP_BITS;
      rem <= rem_next;
    end
  end

endmodule

// File: hw/rtl/rdt_out_reg.sv
// rdt_out_reg: one-word output register that parts the result channel from the core
// depends on rdt_pkg for the result word type
module rdt_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rdt_pkg::rdt_result_t res_in,
  output logic                 space,
  output logic                 valid,
  input  logic                 ready,
  output rdt_pkg::rdt_result_t res_out
);

  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_out <= res_in;
    end
  end

endmodule

// File: hw/rtl/reliable_datagram_tracker.sv
// reliable_datagram_tracker: per-peer selective repeat tracker, top level
// depends on rdt_pkg, rdt_slot_mod and rdt_out_reg
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | to block  | in_valid / in_ready  | func peer seq byte_count time_now
//           |           |                      | resend_timeout
//   out     | from block| out_valid / out_ready| kind peer_out seq_out slot length_out
//           |           |                      | send_ack last
//
// one item at a time: passthrough and rejects go through S_EMIT, send through S_SEND_RD
// and S_SEND_WR, ack through S_MOD and S_ACK, data through S_MOD, S_DATA_RD and S_DATA_EV;
// S_MOD waits on the 8-bit-per-cycle slot remainder unit; tick walks each window slot
// through S_TICK_RD and S_TICK_EV, then S_EMIT; after rst a clearing pass over the
// NUM_PEERS*WINDOW entries clears the valid flags and send counters, with in_ready low
// a stalled out channel holds the core once the output register is full

module reliable_datagram_tracker #(
  parameter int NUM_PEERS = 16,
  parameter int WINDOW    = 32,
  parameter int ACK_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [3:0]  peer,
  input  logic [31:0] seq,
  input  logic [15:0] byte_count,
  input  logic [31:0] time_now,
  input  logic [31:0] resend_timeout,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [3:0]  peer_out,
  output logic [31:0] seq_out,
  output logic [4:0]  slot,
  output logic [16:0] length_out,
  output logic        send_ack,
  output logic        last
);

  localparam int DEPTH  = NUM_PEERS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int P_W    = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam int SL_W   = $clog2(WINDOW);
  localparam logic [31:0] HDR_MASK =
    (ACK_BYTES >= 4) ? 32'hFFFF_FFFF : 32'((64'd1 << (8 * ACK_BYTES)) - 64'd1);

  // fsm codes
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SEND_RD = 4'd2;
  localparam logic [3:0] S_SEND_WR = 4'd3;
  localparam logic [3:0] S_MOD     = 4'd4;
  localparam logic [3:0] S_ACK     = 4'd5;
  localparam logic [3:0] S_DATA_RD = 4'd6;
  localparam logic [3:0] S_DATA_EV = 4'd7;
  localparam logic [3:0] S_TICK_RD = 4'd8;
  localparam logic [3:0] S_TICK_EV = 4'd9;
  localparam logic [3:0] S_EMIT    = 4'd10;

  // window table entry: pending side and seen side share one address
  typedef struct packed {
    logic        pend_valid;
    logic [31:0] pend_time;
    logic [31:0] pend_seq;
    logic [16:0] pend_len;
    logic        seen_valid;
    logic [31:0] seen_seq;
  } tbl_entry_t;

  // per-peer send counter, slot kept alongside to avoid a remainder on send
  typedef struct packed {
    logic [31:0]     seq;
    logic [SL_W-1:0] slot;
  } nseq_entry_t;

  // peer index reduced into the table range
  function automatic logic [P_W-1:0] peer_index(input logic [3:0] pr);
    logic [P_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (pr == 4'(i)) begin
        r = P_W'(i % NUM_PEERS);
      end
    end
    return r;
  endfunction

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [SL_W-1:0]   cursor;

  // latched item
  logic [2:0]  func_r;
  logic [3:0]  peer_r;
  logic [P_W-1:0] p_r;
  logic [ADDR_W-1:0] base_r;
  logic [31:0] seq_r;
  logic [15:0] bytes_r;
  logic [31:0] now_r;
  logic [31:0] tmo_r;
  logic [3:0]  kind_r;

  logic in_acc;
  logic mod_start;
  logic mod_done;
  logic [SL_W-1:0] mod_rem;

  // memories
  tbl_entry_t  tbl_mem [DEPTH];
  tbl_entry_t  tbl_rd;
  logic [ADDR_W-1:0] tbl_addr;
  logic        we_pv;
  logic        wd_pv;
  logic        we_pinfo;
  logic        we_ptime;
  logic        we_seen;
  logic        wd_seen_valid;

  nseq_entry_t nseq_mem [NUM_PEERS];
  nseq_entry_t nseq_rd;
  nseq_entry_t nseq_wd;
  logic [P_W-1:0] nseq_addr;
  logic        nseq_we;

  // result path
  rdt_pkg::rdt_result_t res;
  rdt_pkg::rdt_result_t res_q;
  logic        res_push;
  logic        out_space;

  logic        clr_last;
  logic        dup;
  logic        hit;
  logic        cur_last;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign clr_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign cur_last = (cursor == SL_W'(WINDOW - 1));

  // duplicate when the slot already holds this very sequence number
  assign dup = tbl_rd.seen_valid && (tbl_rd.seen_seq == seq_r);
  // resend when pending and the wrapped age reaches the timeout
  assign hit = tbl_rd.pend_valid && ((now_r - tbl_rd.pend_time) >= tmo_r);

  // ack and data both need the slot of the received sequence number
  assign mod_start = in_acc && (
    (func == rdt_pkg::FUNC_ACK && byte_count == 16'(ACK_BYTES)) ||
    (func == rdt_pkg::FUNC_DATA && byte_count >= 16'(ACK_BYTES)));

  rdt_slot_mod #(
    .WINDOW(WINDOW)
  ) u_slot_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (seq & HDR_MASK),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // table address and write strobes per state
  always_comb begin
    tbl_addr      = base_r;
    we_pv         = 1'b0;
    wd_pv         = 1'b0;
    we_pinfo      = 1'b0;
    we_ptime      = 1'b0;
    we_seen       = 1'b0;
    wd_seen_valid = 1'b0;
    unique case (state)
      S_CLEAR: begin
        tbl_addr = clr_addr;
        we_pv    = 1'b1;
        we_seen  = 1'b1;
      end
      S_SEND_WR: begin
        tbl_addr = base_r + ADDR_W'(nseq_rd.slot);
        we_pv    = out_space;
        wd_pv    = 1'b1;
        we_pinfo = out_space;
        we_ptime = out_space;
      end
      S_ACK: begin
        tbl_addr = base_r + ADDR_W'(mod_rem);
        we_pv    = out_space;
      end
      S_DATA_RD: begin
        tbl_addr = base_r + ADDR_W'(mod_rem);
      end
      S_DATA_EV: begin
        tbl_addr      = base_r + ADDR_W'(mod_rem);
        we_seen       = out_space && !dup;
        wd_seen_valid = 1'b1;
      end
      S_TICK_RD: begin
        tbl_addr = base_r + ADDR_W'(cursor);
      end
      S_TICK_EV: begin
        tbl_addr = base_r + ADDR_W'(cursor);
        we_ptime = hit && out_space;
      end
      default: begin
        tbl_addr = base_r;
      end
    endcase
  end

  // window table: single port, field write enables, registered read
  always_ff @(posedge clk) begin
    if (we_pv) begin
      tbl_mem[tbl_addr].pend_valid <= wd_pv;
    end
    if (we_pinfo) begin
      tbl_mem[tbl_addr].pend_seq <= nseq_rd.seq;
      tbl_mem[tbl_addr].pend_len <= {1'b0, bytes_r} + 17'(ACK_BYTES);
    end
    if (we_ptime) begin
      tbl_mem[tbl_addr].pend_time <= now_r;
    end
    if (we_seen) begin
      tbl_mem[tbl_addr].seen_valid <= wd_seen_valid;
      tbl_mem[tbl_addr].seen_seq   <= seq_r;
    end
    tbl_rd <= tbl_mem[tbl_addr];
  end

  // send counter table
  always_comb begin
    nseq_addr = p_r;
    nseq_we   = 1'b0;
    nseq_wd   = '0;
    if (state == S_CLEAR) begin
      nseq_addr = clr_addr[P_W-1:0];
      nseq_we   = (clr_addr < ADDR_W'(NUM_PEERS));
    end else if (state == S_SEND_WR) begin
      nseq_we      = out_space;
      nseq_wd.seq  = nseq_rd.seq + 32'd1;
      nseq_wd.slot = (nseq_rd.slot == SL_W'(WINDOW - 1)) ? '0 : nseq_rd.slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (nseq_we) begin
      nseq_mem[nseq_addr] <= nseq_wd;
    end
    nseq_rd <= nseq_mem[nseq_addr];
  end

  // result word and push per state
  always_comb begin
    res          = '0;
    res.peer     = peer_r;
    res.last     = 1'b1;
    res_push     = 1'b0;
    unique case (state)
      S_SEND_WR: begin
        res_push  = out_space;
        res.kind  = rdt_pkg::KIND_STORED;
        res.seq   = nseq_rd.seq;
        res.slot  = 5'(nseq_rd.slot);
        res.len   = {1'b0, bytes_r} + 17'(ACK_BYTES);
      end
      S_ACK: begin
        res_push  = out_space;
        res.kind  = rdt_pkg::KIND_ACK_CLEARED;
        res.seq   = seq_r;
        res.slot  = 5'(mod_rem);
      end
      S_DATA_EV: begin
        res_push     = out_space;
        res.kind     = dup ? rdt_pkg::KIND_DUPLICATE : rdt_pkg::KIND_DELIVERED;
        res.seq      = seq_r;
        res.slot     = 5'(mod_rem);
        res.len      = dup ? 17'd0 : {1'b0, bytes_r - 16'(ACK_BYTES)};
        res.send_ack = 1'b1;
      end
      S_TICK_EV: begin
        res_push  = hit && out_space;
        res.kind  = rdt_pkg::KIND_RESEND;
        res.seq   = tbl_rd.pend_seq;
        res.slot  = 5'(cursor);
        res.len   = tbl_rd.pend_len;
        res.last  = 1'b0;
      end
      S_EMIT: begin
        res_push  = out_space;
        res.kind  = kind_r;
        res.len   = (kind_r == rdt_pkg::KIND_PASSED) ? {1'b0, bytes_r} : 17'd0;
      end
      default: begin
        res_push  = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (func == rdt_pkg::FUNC_SEND) begin
            state_next = S_SEND_RD;
          end else if (func == rdt_pkg::FUNC_TICK) begin
            state_next = S_TICK_RD;
          end else if (mod_start) begin
            state_next = S_MOD;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_SEND_RD: state_next = S_SEND_WR;
      S_SEND_WR: begin
        if (out_space) begin
          state_next = S_IDLE;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = (func_r == rdt_pkg::FUNC_ACK) ? S_ACK : S_DATA_RD;
        end
      end
      S_ACK: begin
        if (out_space) begin
          state_next = S_IDLE;
        end
      end
      S_DATA_RD: state_next = S_DATA_EV;
      S_DATA_EV: begin
        if (out_space) begin
          state_next = S_IDLE;
        end
      end
      S_TICK_RD: state_next = S_TICK_EV;
      S_TICK_EV: begin
        if (!hit || out_space) begin
          state_next = cur_last ? S_EMIT : S_TICK_RD;
        end
      end
      S_EMIT: begin
        if (out_space) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cursor   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      // walk cursor, back to zero between items
      if (state == S_TICK_EV && (!hit || out_space)) begin
        cursor <= cur_last ? '0 : cursor + 1'b1;
      end
    end
  end

  // item latch and the code for the word emitted from S_EMIT
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= func;
      peer_r  <= peer;
      p_r     <= peer_index(peer);
      base_r  <= ADDR_W'(peer_index(peer)) * ADDR_W'(WINDOW);
      seq_r   <= seq & HDR_MASK;
      bytes_r <= byte_count;
      now_r   <= time_now;
      tmo_r   <= resend_timeout;
      if (func == rdt_pkg::FUNC_ACK) begin
        kind_r <= rdt_pkg::KIND_BAD_ACK;
      end else if (func == rdt_pkg::FUNC_DATA) begin
        kind_r <= rdt_pkg::KIND_TOO_SHORT;
      end else begin
        kind_r <= rdt_pkg::KIND_PASSED;
      end
    end else if (state == S_TICK_EV && cur_last && (!hit || out_space)) begin
      kind_r <= rdt_pkg::KIND_TICK_DONE;
    end
  end

  rdt_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .res_in  (res),
    .space   (out_space),
    .valid   (out_valid),
    .ready   (out_ready),
    .res_out (res_q)
  );

  assign kind       = res_q.kind;
  assign peer_out   = res_q.peer;
  assign seq_out    = res_q.seq;
  assign slot       = res_q.slot;
  assign length_out = res_q.len;
  assign send_ack   = res_q.send_ack;
  assign last       = res_q.last;

  // a result is only pushed when the output register can take it
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_space)
    else $error("result pushed into a full output register");

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // the final word of an item returns the core to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_push && res.last |=> state == S_IDLE)
    else $error("core not idle after final word");

  // table writes never happen while the tick walk only reads
  a_tick_rd_nowrite: assert property (@(posedge clk) disable iff (rst)
    state == S_TICK_RD |-> !(we_pv || we_pinfo || we_ptime || we_seen))
    else $error("table written during tick read");

endmodule

// File: test/reliable_datagram_tracker_tb.sv
// reliable_datagram_tracker_tb: self-checking bench for the datagram reliability tracker
// depends on rdt_pkg and reliable_datagram_tracker; the expected words come from a
// behavioral copy of the per-peer send window and receive tables kept in this file
module reliable_datagram_tracker_tb;

  localparam int NUM_PEERS  = 16;
  localparam int WINDOW     = 32;
  localparam int ACK_BYTES  = 4;
  localparam int TABLE_SIZE = NUM_PEERS * WINDOW;

  // function codes 4 and up all pass the frame through untouched
  localparam logic [2:0] FUNC_PASS = 3'd4;

  localparam int RANDOM_WORDS = 140;
  localparam int HOLD_AFTER   = 40;   // accepted words before the long out stall
  localparam int LONG_HOLD    = 400;  // cycles of that stall
  localparam int SETTLE       = 100;  // tail after the last expected word

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  peer;
    logic [31:0] seq;
    logic [15:0] bytes;
    logic [31:0] now;
    logic [31:0] timeout;
    bit          drain;  // offer only once every expected word has come back
  } dgram_word_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PATTERN} ready_mode_t;

  // clock, reset and block ports; the inputs all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = '0;
  logic [3:0]  peer = '0;
  logic [31:0] seq = '0;
  logic [15:0] byte_count = '0;
  logic [31:0] time_now = '0;
  logic [31:0] resend_timeout = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  kind;
  logic [3:0]  peer_out;
  logic [31:0] seq_out;
  logic [4:0]  slot;
  logic [16:0] length_out;
  logic        send_ack;
  logic        last;

  reliable_datagram_tracker #(
    .NUM_PEERS(NUM_PEERS),
    .WINDOW(WINDOW),
    .ACK_BYTES(ACK_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .peer(peer),
    .seq(seq),
    .byte_count(byte_count),
    .time_now(time_now),
    .resend_timeout(resend_timeout),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .peer_out(peer_out),
    .seq_out(seq_out),
    .slot(slot),
    .length_out(length_out),
    .send_ack(send_ack),
    .last(last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run (clearing pass, full-window
  // ticks, long out stall and random idling included)
  initial begin
    #1600000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // tracker state as the block should hold it
  // ---------------------------------------------------------------------
  logic [31:0] peer_next_seq [NUM_PEERS];
  logic        win_busy  [TABLE_SIZE];
  logic [31:0] win_stamp [TABLE_SIZE];
  logic [31:0] win_seq   [TABLE_SIZE];
  logic [16:0] win_len   [TABLE_SIZE];
  logic        rx_seen   [TABLE_SIZE];
  logic [31:0] rx_seq    [TABLE_SIZE];

  rdt_pkg::rdt_result_t due_results[$];   // words still owed by the block, oldest first
  dgram_word_t stim_q[$];                 // words not yet offered

  int accepted_words;
  int mism_count;
  logic drained;                 // registered copy of "nothing owed"
  int total_words;

  function automatic void queue_result(logic [3:0] k, logic [3:0] p, logic [31:0] s,
                                       logic [4:0] sl, logic [16:0] l, logic a,
                                       logic lst);
    rdt_pkg::rdt_result_t r;
    r = {k, p, s, sl, l, a, lst};
    due_results.push_back(r);
  endfunction

  // received headers only carry 8*ACK_BYTES bits of sequence
  function automatic logic [31:0] hdr_bits(logic [31:0] a);
    if (ACK_BYTES >= 4) return a;
    return a & ((32'd1 << (8 * ACK_BYTES)) - 32'd1);
  endfunction

  // one accepted word: update the tables and queue what the block must return
  task automatic advance_tracker(input logic [2:0] f, input logic [3:0] p_in,
                                 input logic [31:0] s_in, input logic [15:0] b,
                                 input logic [31:0] t, input logic [31:0] tmo);
    int unsigned pi;
    int unsigned sl;
    int unsigned idx;
    logic [31:0] a;
    logic [31:0] sn;
    pi = p_in % NUM_PEERS;
    a = hdr_bits(s_in);
    case (f)
      rdt_pkg::FUNC_SEND: begin
        sn = peer_next_seq[pi];
        sl = sn % 32'(WINDOW);
        idx = pi * WINDOW + sl;
        peer_next_seq[pi] = sn + 32'd1;
        win_busy[idx]  = 1'b1;
        win_stamp[idx] = t;
        win_seq[idx]   = sn;
        win_len[idx]   = 17'(b) + 17'(ACK_BYTES);
        queue_result(rdt_pkg::KIND_STORED, p_in, sn, 5'(sl), win_len[idx], 1'b0, 1'b1);
      end
      rdt_pkg::FUNC_ACK: begin
        sl = a % 32'(WINDOW);
        idx = pi * WINDOW + sl;
        if (b != 16'(ACK_BYTES)) begin
          queue_result(rdt_pkg::KIND_BAD_ACK, p_in, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          // an idle slot is cleared all the same
          win_busy[idx] = 1'b0;
          queue_result(rdt_pkg::KIND_ACK_CLEARED, p_in, a, 5'(sl), '0, 1'b0, 1'b1);
        end
      end
      rdt_pkg::FUNC_DATA: begin
        sl = a % 32'(WINDOW);
        idx = pi * WINDOW + sl;
        if (b < 16'(ACK_BYTES)) begin
          queue_result(rdt_pkg::KIND_TOO_SHORT, p_in, '0, '0, '0, 1'b0, 1'b1);
        end else if (rx_seen[idx] && rx_seq[idx] == a) begin
          queue_result(rdt_pkg::KIND_DUPLICATE, p_in, a, 5'(sl), '0, 1'b1, 1'b1);
        end else begin
          rx_seen[idx] = 1'b1;
          rx_seq[idx]  = a;
          queue_result(rdt_pkg::KIND_DELIVERED, p_in, a, 5'(sl),
                       17'(b - 16'(ACK_BYTES)), 1'b1, 1'b1);
        end
      end
      rdt_pkg::FUNC_TICK: begin
        for (int i = 0; i < WINDOW; i++) begin
          idx = pi * WINDOW + i;
          // age wraps with the millisecond counter
          if (win_busy[idx] && (t - win_stamp[idx]) >= tmo) begin
            win_stamp[idx] = t;
            queue_result(rdt_pkg::KIND_RESEND, p_in, win_seq[idx], 5'(i), win_len[idx],
                         1'b0, 1'b0);
          end
        end
        queue_result(rdt_pkg::KIND_TICK_DONE, p_in, '0, '0, '0, 1'b0, 1'b1);
      end
      default: begin
        queue_result(rdt_pkg::KIND_PASSED, p_in, '0, '0, 17'(b), 1'b0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // monitor: checks out words, predicts on accepted in words
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : observe
    rdt_pkg::rdt_result_t got;
    rdt_pkg::rdt_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_PEERS; i++) peer_next_seq[i] = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        win_busy[i] = 1'b0;
        rx_seen[i]  = 1'b0;
      end
      accepted_words <= 0;
      mism_count <= 0;
      drained <= 1'b1;
    end else begin
      // out side first: a word never leaves in the cycle its input is taken
      if (out_valid && out_ready) begin
        got = {kind, peer_out, seq_out, slot, length_out, send_ack, last};
        if (due_results.size() == 0) begin
          if (mism_count < 10)
            $display("mismatch: unexpected word kind %0d peer %0d seq %h slot %0d len %0d",
                     got.kind, got.peer, got.seq, got.slot, got.len);
          mism_count <= mism_count + 1;
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.peer !== want.peer || got.seq !== want.seq ||
              got.slot !== want.slot || got.len !== want.len ||
              got.send_ack !== want.send_ack || got.last !== want.last) begin
            if (mism_count < 10) begin
              $display("mismatch exp kind %0d peer %0d seq %h slot %0d len %0d ack %0b last %0b",
                       want.kind, want.peer, want.seq, want.slot, want.len, want.send_ack,
                       want.last);
              $display("         got kind %0d peer %0d seq %h slot %0d len %0d ack %0b last %0b",
                       got.kind, got.peer, got.seq, got.slot, got.len, got.send_ack,
                       got.last);
            end
            mism_count <= mism_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_tracker(func, peer, seq, byte_count, time_now, resend_timeout);
        accepted_words <= accepted_words + 1;
      end
      drained <= (due_results.size() == 0);
    end
  end

  // ---------------------------------------------------------------------
  // driver: bursts of words with random gaps, fed from stim_q
  // ---------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive
    dgram_word_t w;
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= $urandom_range(1, 12);
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      // channel is free after this edge, pick the next word or idle
      offer = 1'b0;
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (stim_q.size() != 0 && !(stim_q[0].drain && (in_valid || !drained))) begin
        // a drain word waits for a cycle with nothing just taken and nothing owed
        w = stim_q.pop_front();
        offer = 1'b1;
        func <= w.func;
        peer <= w.peer;
        seq <= w.seq;
        byte_count <= w.bytes;
        time_now <= w.now;
        resend_timeout <= w.timeout;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          // about a quarter of bursts run straight into the next one
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------
  // receiver: ready pattern changes each time the 6-bit mode age wraps, one long stall
  // ---------------------------------------------------------------------
  ready_mode_t ready_mode;
  logic [5:0]  mode_age;
  logic [7:0]  ready_pat;
  int          hold_left;
  logic        hold_done;

  always @(posedge clk) begin : receive
    if (rst) begin
      out_ready <= 1'b0;
      ready_mode <= RX_FREE;
      mode_age <= '0;
      ready_pat <= 8'h5b;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_words >= HOLD_AFTER) begin
      // long stall: output register fills, the core backs up into in_ready
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      mode_age <= mode_age + 6'd1;
      if (mode_age == 6'd63) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        ready_pat <= 8'($urandom) | 8'h01;
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[7:1]};
      end
      case (ready_mode)
        RX_FREE:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
        RX_SLOW:    out_ready <= ($urandom_range(0, 4) == 0);
        RX_PATTERN: out_ready <= ready_pat[0];
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  logic [31:0] gen_clock;
  logic [31:0] gen_next [NUM_PEERS];   // sequence the block will hand out next
  logic [31:0] data_base [NUM_PEERS];  // small per-peer pool so repeats happen
  bit          drain_next;
  int          window_fills;

  task automatic add_word(input logic [2:0] f, input logic [3:0] p, input logic [31:0] s,
                          input logic [15:0] b, input logic [31:0] t,
                          input logic [31:0] tmo);
    dgram_word_t w;
    w.func = f;
    w.peer = p;
    w.seq = s;
    w.bytes = b;
    w.now = t;
    w.timeout = tmo;
    w.drain = drain_next || ($urandom_range(0, 49) == 0);
    drain_next = 1'b0;
    if (f == rdt_pkg::FUNC_SEND) gen_next[p % NUM_PEERS] += 32'd1;
    stim_q.push_back(w);
  endtask

  // mostly small steps, now and then a jump across the whole range
  function automatic logic [31:0] now_ms();
    if ($urandom_range(0, 19) == 0) gen_clock += $urandom;
    else gen_clock += $urandom_range(0, 60);
    return gen_clock;
  endfunction

  function automatic logic [31:0] pick_timeout();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return $urandom_range(0, 200);
      2:       return $urandom_range(0, 2000);
      3:       return $urandom;
      default: return '1;
    endcase
  endfunction

  function automatic logic [15:0] frame_bytes(int unsigned lo);
    if ($urandom_range(0, 7) == 0) return 16'($urandom_range(lo, 65535));
    return 16'($urandom_range(lo, 1500));
  endfunction

  task automatic random_part();
    logic [3:0]  p;
    logic [15:0] b;
    logic [31:0] s;
    int unsigned back;
    int unsigned pick;
    int unsigned n;
    p = 4'($urandom_range(0, NUM_PEERS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      add_word(rdt_pkg::FUNC_SEND, p, $urandom, frame_bytes(0), now_ms(), $urandom);
    end else if (pick < 36) begin
      // ack of a recently sent sequence, sometimes malformed or stray
      b = 16'(ACK_BYTES);
      if ($urandom_range(0, 9) == 0) begin
        b = 16'($urandom_range(0, 65535));
        if (b == 16'(ACK_BYTES)) b = b + 16'd1;
      end
      back = $urandom_range(0, 40);
      if (back >= gen_next[p]) back = 0;
      s = gen_next[p] - 32'd1 - back;
      if (gen_next[p] == 0 || $urandom_range(0, 9) == 0) s = $urandom;
      add_word(rdt_pkg::FUNC_ACK, p, s, b, now_ms(), $urandom);
    end else if (pick < 56) begin
      b = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, ACK_BYTES - 1))
                                      : frame_bytes(ACK_BYTES);
      s = ($urandom_range(0, 9) == 0) ? $urandom : data_base[p] + $urandom_range(0, 47);
      add_word(rdt_pkg::FUNC_DATA, p, s, b, now_ms(), $urandom);
    end else if (pick < 66) begin
      add_word(rdt_pkg::FUNC_TICK, p, $urandom, 16'($urandom), now_ms(), pick_timeout());
    end else if (pick < 74) begin
      add_word(3'(FUNC_PASS + $urandom_range(0, 3)), p, $urandom, 16'($urandom), now_ms(),
               $urandom);
    end else if (pick < 88) begin
      // short exchange: a few sends, a tick, some acks, another tick
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        add_word(rdt_pkg::FUNC_SEND, p, $urandom, frame_bytes(0), now_ms(), $urandom);
      add_word(rdt_pkg::FUNC_TICK, p, $urandom, 16'($urandom), now_ms(),
               $urandom_range(0, 100));
      for (int i = 0; i < n; i++)
        if ($urandom_range(0, 1) == 1)
          add_word(rdt_pkg::FUNC_ACK, p, gen_next[p] - 32'(n) + 32'(i), 16'(ACK_BYTES),
                   now_ms(), $urandom);
      add_word(rdt_pkg::FUNC_TICK, p, $urandom, 16'($urandom), now_ms(),
               $urandom_range(0, 100));
    end else if (pick < 92 && window_fills < 2) begin
      // wrap the whole window of one peer, then resend all of it
      window_fills++;
      n = WINDOW + $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        add_word(rdt_pkg::FUNC_SEND, p, $urandom, 16'($urandom_range(0, 64)), now_ms(),
                 $urandom);
      add_word(rdt_pkg::FUNC_TICK, p, $urandom, 16'($urandom), now_ms(), '0);
    end else begin
      add_word(3'($urandom), p, $urandom, 16'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin : main
    int directed_words;
    drain_next = 1'b0;
    window_fills = 0;
    for (int i = 0; i < NUM_PEERS; i++) begin
      gen_next[i] = '0;
      data_base[i] = $urandom;
    end

    // directed: passthrough codes and field extremes
    add_word(FUNC_PASS, 4'd0, '0, 16'd0, 32'd0, '0);
    add_word(3'd7, 4'd15, '1, 16'hffff, '1, '1);
    // sends with the smallest and largest payload
    add_word(rdt_pkg::FUNC_SEND, 4'd0, '0, 16'd0, 32'd100, '0);
    add_word(rdt_pkg::FUNC_SEND, 4'd0, '1, 16'hffff, 32'd110, '0);
    add_word(rdt_pkg::FUNC_SEND, 4'd15, '0, 16'd100, 32'hffff_fff0, '0);
    // acks: wrong length, proper, and one for a slot never used
    add_word(rdt_pkg::FUNC_ACK, 4'd0, 32'd0, 16'(ACK_BYTES - 1), 32'd120, '0);
    add_word(rdt_pkg::FUNC_ACK, 4'd0, 32'd0, 16'(ACK_BYTES), 32'd120, '0);
    add_word(rdt_pkg::FUNC_ACK, 4'd3, '1, 16'(ACK_BYTES), 32'd120, '0);
    // data: too short, header only, repeat, slot reuse, then the old one again
    add_word(rdt_pkg::FUNC_DATA, 4'd2, 32'd5, 16'(ACK_BYTES - 1), 32'd130, '0);
    add_word(rdt_pkg::FUNC_DATA, 4'd2, 32'd5, 16'd0, 32'd130, '0);
    add_word(rdt_pkg::FUNC_DATA, 4'd2, 32'd5, 16'(ACK_BYTES), 32'd130, '0);
    add_word(rdt_pkg::FUNC_DATA, 4'd2, 32'd5, 16'd200, 32'd130, '0);
    add_word(rdt_pkg::FUNC_DATA, 4'd2, 32'd37, 16'd10, 32'd130, '0);
    add_word(rdt_pkg::FUNC_DATA, 4'd2, 32'd5, 16'd10, 32'd130, '0);
    add_word(rdt_pkg::FUNC_DATA, 4'd2, '1, 16'hffff, 32'd130, '0);
    // ticks: empty peer, not yet aged, aged
    add_word(rdt_pkg::FUNC_TICK, 4'd5, '0, 16'd0, 32'd140, '0);
    add_word(rdt_pkg::FUNC_TICK, 4'd0, '0, 16'd0, 32'd110, '1);
    add_word(rdt_pkg::FUNC_TICK, 4'd0, '0, 16'd0, 32'd150, '0);
    // age across the clock wrap, exactly at the timeout, then one short of it
    add_word(rdt_pkg::FUNC_TICK, 4'd15, '0, 16'd0, 32'h10, 32'h20);
    add_word(rdt_pkg::FUNC_TICK, 4'd15, '0, 16'd0, 32'h2f, 32'h20);
    add_word(rdt_pkg::FUNC_ACK, 4'd15, 32'd0, 16'(ACK_BYTES), 32'h30, '0);
    directed_words = stim_q.size();

    // random part starts after a full drain, clock set to wrap soon
    gen_clock = 32'hffff_f800;
    drain_next = 1'b1;
    while (stim_q.size() < directed_words + RANDOM_WORDS) random_part();
    total_words = stim_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // everything taken and nothing owed, then let stray words show up
    while (!(accepted_words == total_words && drained)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mism_count == 0 && drained) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
